>>> src/tcpr_pkg.sv
// Shared types, codes and wrap-aware sequence helpers for the TCP
// reassembly interval tracker. No dependencies.
package tcpr_pkg;

  localparam int SeqW = 32;
  localparam int LenW = 25;
  localparam logic [LenW-1:0] SizeCap = 25'd16777216;
  localparam logic [SeqW-1:0] SeqHalf = 32'h7FFF_FFFF;

  typedef logic [SeqW-1:0] seq_t;
  typedef logic [LenW-1:0] len_t;

  typedef enum logic [1:0] {
    CMD_PUT     = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_ZERO_LEN = 3'd1,
    STS_BEFORE   = 3'd2,
    STS_BEYOND   = 3'd3,
    STS_FULL     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_MERGE_WR,
    ST_MOVE_DN,
    ST_MOVE_UP,
    ST_INSERT,
    ST_HEAD,
    ST_DONE
  } state_t;

  // Result of the shared compare unit for one stored range.
  typedef struct packed {
    logic touch;
    logic past_seg;
    seq_t merge_start;
    len_t merge_len;
  } unit_res_t;

  function automatic seq_t seq_min(seq_t a, seq_t b);
    seq_t r;
    if (a == b) r = a;
    else if (a < b) r = ((b - a) <= SeqHalf) ? a : b;
    else r = ((a - b) <= SeqHalf) ? b : a;
    return r;
  endfunction

  function automatic seq_t seq_max(seq_t a, seq_t b);
    seq_t r;
    if (a == b) r = a;
    else if (a < b) r = ((b - a) <= SeqHalf) ? b : a;
    else r = ((a - b) <= SeqHalf) ? a : b;
    return r;
  endfunction

endpackage

>>> src/tcpr_merge_unit.sv
// Shared range compare/merge unit: tests one stored range against the
// running merged segment. Depends on tcpr_pkg.
module tcpr_merge_unit
  import tcpr_pkg::*;
(
  input  seq_t      cur_start,
  input  len_t      cur_len,
  input  seq_t      ent_start,
  input  len_t      ent_len,
  input  seq_t      seg_end,
  output unit_res_t res
);

  seq_t cur_end1, ent_end1, lo, hi, diff;

  always_comb begin
    cur_end1 = cur_start + seq_t'(cur_len) + 32'd1;
    ent_end1 = ent_start + seq_t'(ent_len) + 32'd1;
    lo       = seq_min(cur_start, ent_start);
    hi       = seq_max(cur_start + seq_t'(cur_len), ent_start + seq_t'(ent_len));
    diff     = hi - lo;
    res.touch = !((seq_min(cur_end1, ent_start) == cur_end1) ||
                  (seq_min(ent_end1, cur_start) == ent_end1));
    res.past_seg    = (seq_max(seg_end, ent_start) == ent_start);
    res.merge_start = lo;
    res.merge_len   = diff[LenW-1:0];
  end

endmodule

>>> src/tcp_reassembly_interval_tracker.sv
// Top level of the TCP reassembly interval tracker: sequencer, range
// table and output register. Depends on tcpr_pkg and tcpr_merge_unit.
//
// Usage:
//   in_* channel carries one command per transfer: in_tuser = cmd (put,
//   remove, restart), in_tdata = {seg_len, seq}. out_* returns exactly one
//   result per command: status, done_len, contiguous_len, next_seq,
//   total_len and range_count. cfg_wr_en/cfg_wr_data write buffer_size
//   (capped at 16 MiB internally); the user must write it only while the
//   block is idle, which the block itself does not enforce. Restart,
//   refused puts and removes that keep the first range go from the check
//   straight to the result. A remove that frees the first range moves the
//   remaining ranges down. A put scans the stored ranges; if it touches none
//   and the table is full, it is refused; else it writes the merged range
//   and moves later entries down to close the gap, or moves entries up to
//   open a slot and inserts, and then updates the ready length. The scan
//   uses the single merge unit and moves use the one-entry-per-cycle table
//   port. One command is in flight at a time; in_tready stays low meanwhile
//   and returns in the same cycle that the result is loaded into the output
//   register. Reset empties the table, zeroes head sequence, ready and total
//   lengths and sets buffer_size to 65536. A stalled receiver holds the
//   result in the output register; the next command may be taken meanwhile
//   but its result waits until it drains.
module tcp_reassembly_interval_tracker
  import tcpr_pkg::*;
#(
  parameter int RANGE_SLOTS = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic [24:0]  cfg_wr_data,    // buffer_size
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,       // seq[31:0], seg_len[56:32], zero fill
  input  logic [1:0]   in_tuser,       // cmd
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata       // status[2:0], done_len[27:3],
                                       // contiguous_len[52:28], next_seq[84:53],
                                       // total_len[116:85], range_count[120:117]
);

  localparam int AW = $clog2(RANGE_SLOTS);
  localparam int CW = $clog2(RANGE_SLOTS + 1);
  localparam logic [CW-1:0] Slots = CW'(RANGE_SLOTS);

  // Range table: one write and one selected read per cycle.
  seq_t start_r [RANGE_SLOTS];
  len_t len_r   [RANGE_SLOTS];

  state_t state_r, state_nxt;
  len_t   buf_size_r;
  seq_t   head_r, head_nxt, total_r, total_nxt;
  len_t   ready_r, ready_nxt;
  logic [CW-1:0] used_r, used_nxt;
  cmd_t   cmd_r;
  seq_t   seq_r;
  len_t   seglen_r;
  seq_t   ns_r, ns_nxt;
  len_t   nl_r, nl_nxt;
  logic [CW-1:0] idx_r, idx_nxt, first_r, first_nxt, last_r, last_nxt;
  logic [CW-1:0] gap_r, gap_nxt, pos_r, pos_nxt;
  logic   found_r, found_nxt;
  status_t sts_r, sts_nxt;
  len_t   done_r, done_nxt;

  logic          out_valid_r;
  logic [120:0]  out_data_r;

  logic          wr_en;
  logic [AW-1:0] wr_idx, rd_idx;
  seq_t          wr_start, rd_start;
  len_t          wr_len, rd_len;
  unit_res_t     ures;
  len_t          size_cap, rem_n;
  logic [32:0]   end_off;
  logic [CW-1:0] k_minus;
  logic          load_out;
  logic          in_fire;

  assign in_fire   = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_tready);
  assign k_minus   = idx_r - CW'(1);

  assign size_cap = (buf_size_r > SizeCap) ? SizeCap : buf_size_r;
  assign end_off  = {1'b0, seq_r - head_r} + 33'(seglen_r);
  assign rem_n    = (seglen_r < ready_r) ? seglen_r : ready_r;

  assign rd_idx   = (state_r == ST_MOVE_UP) ? k_minus[AW-1:0] : idx_r[AW-1:0];
  assign rd_start = start_r[rd_idx];
  assign rd_len   = len_r[rd_idx];

  tcpr_merge_unit u_unit (
    .cur_start (ns_r),
    .cur_len   (nl_r),
    .ent_start (rd_start),
    .ent_len   (rd_len),
    .seg_end   (seq_r + seq_t'(seglen_r)),
    .res       (ures)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_fire) state_nxt = ST_CHECK;
      ST_CHECK: begin
        state_nxt = ST_DONE;
        if (cmd_r == CMD_PUT && seglen_r != '0 && seq_min(head_r, seq_r) == head_r &&
            end_off <= 33'(size_cap)) begin
          state_nxt = ST_SCAN;
        end else if (cmd_r == CMD_REMOVE && rem_n != '0 && used_r != '0 &&
                     rem_n >= len_r[0]) begin
          state_nxt = ST_MOVE_DN;
        end
      end
      ST_SCAN: begin
        if (idx_r == used_r || (!ures.touch && (found_r || ures.past_seg))) begin
          if (found_r) state_nxt = ST_MERGE_WR;
          else if (used_r >= Slots) state_nxt = ST_DONE;
          else state_nxt = ST_MOVE_UP;
        end
      end
      ST_MERGE_WR: state_nxt = ST_MOVE_DN;
      ST_MOVE_DN: if (idx_r >= used_r) state_nxt = (cmd_r == CMD_PUT) ? ST_HEAD : ST_DONE;
      ST_MOVE_UP: if (idx_r == pos_r) state_nxt = ST_INSERT;
      ST_INSERT:  state_nxt = ST_HEAD;
      ST_HEAD:    state_nxt = ST_DONE;
      ST_DONE:    if (load_out) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and table writes.
  always_comb begin
    head_nxt  = head_r;
    ready_nxt = ready_r;
    total_nxt = total_r;
    used_nxt  = used_r;
    ns_nxt    = ns_r;
    nl_nxt    = nl_r;
    idx_nxt   = idx_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    gap_nxt   = gap_r;
    pos_nxt   = pos_r;
    found_nxt = found_r;
    sts_nxt   = sts_r;
    done_nxt  = done_r;
    wr_en     = 1'b0;
    wr_idx    = '0;
    wr_start  = rd_start;
    wr_len    = rd_len;
    unique case (state_r)
      ST_CHECK: begin
        sts_nxt  = STS_OK;
        done_nxt = '0;
        unique case (cmd_r)
          CMD_PUT: begin
            if (seglen_r == '0) sts_nxt = STS_ZERO_LEN;
            else if (seq_min(head_r, seq_r) != head_r) sts_nxt = STS_BEFORE;
            else if (end_off > 33'(size_cap)) sts_nxt = STS_BEYOND;
            ns_nxt    = seq_r;
            nl_nxt    = seglen_r;
            idx_nxt   = '0;
            found_nxt = 1'b0;
          end
          CMD_REMOVE: begin
            done_nxt = rem_n;
            if (rem_n != '0) begin
              head_nxt  = head_r + seq_t'(rem_n);
              ready_nxt = ready_r - rem_n;
              if (used_r != '0) begin
                if (rem_n < len_r[0]) begin
                  // Trim the first range in place.
                  wr_en    = 1'b1;
                  wr_idx   = '0;
                  wr_start = start_r[0] + seq_t'(rem_n);
                  wr_len   = len_r[0] - rem_n;
                end else begin
                  idx_nxt = CW'(1);
                  gap_nxt = CW'(1);
                end
              end
            end
          end
          CMD_RESTART: begin
            head_nxt  = seq_r;
            used_nxt  = '0;
            ready_nxt = '0;
            total_nxt = '0;
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (idx_r == used_r || (!ures.touch && (found_r || ures.past_seg))) begin
          if (!found_r) begin
            if (used_r >= Slots) sts_nxt = STS_FULL;
            pos_nxt = (used_r == '0 || seq_min(seq_r, start_r[0]) == seq_r) ? '0 : idx_r;
            idx_nxt = used_r;
          end
        end else if (ures.touch) begin
          ns_nxt    = ures.merge_start;
          nl_nxt    = ures.merge_len;
          if (!found_r) first_nxt = idx_r;
          last_nxt  = idx_r;
          found_nxt = 1'b1;
          idx_nxt   = idx_r + CW'(1);
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      ST_MERGE_WR: begin
        wr_en    = 1'b1;
        wr_idx   = first_r[AW-1:0];
        wr_start = ns_r;
        wr_len   = nl_r;
        idx_nxt  = last_r + CW'(1);
        gap_nxt  = last_r - first_r;
      end
      ST_MOVE_DN: begin
        if (idx_r >= used_r) begin
          used_nxt = used_r - gap_r;
        end else begin
          wr_en   = 1'b1;
          wr_idx  = AW'(idx_r - gap_r);
          idx_nxt = idx_r + CW'(1);
        end
      end
      ST_MOVE_UP: begin
        if (idx_r != pos_r) begin
          wr_en   = 1'b1;
          wr_idx  = idx_r[AW-1:0];
          idx_nxt = k_minus;
        end
      end
      ST_INSERT: begin
        wr_en    = 1'b1;
        wr_idx   = pos_r[AW-1:0];
        wr_start = seq_r;
        wr_len   = seglen_r;
        used_nxt = used_r + CW'(1);
      end
      ST_HEAD: begin
        done_nxt = seglen_r;
        if (used_r != '0 && head_r == start_r[0]) begin
          total_nxt = total_r + seq_t'(len_r[0]) - seq_t'(ready_r);
          ready_nxt = len_r[0];
        end
      end
      default: ;
    endcase
  end

  // Table storage: payload only, no reset.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_r[wr_idx] <= wr_start;
      len_r[wr_idx]   <= wr_len;
    end
  end

  // Latch the command on a transfer; register the datapath state and load the output data.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= cmd_t'(in_tuser);
      seq_r    <= in_tdata[31:0];
      seglen_r <= in_tdata[56:32];
    end
    ns_r    <= ns_nxt;
    nl_r    <= nl_nxt;
    idx_r   <= idx_nxt;
    first_r <= first_nxt;
    last_r  <= last_nxt;
    gap_r   <= gap_nxt;
    pos_r   <= pos_nxt;
    found_r <= found_nxt;
    sts_r   <= sts_nxt;
    done_r  <= done_nxt;
    if (load_out) begin
      out_data_r <= {4'(used_r), total_r, head_r, ready_r, done_r, sts_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      buf_size_r  <= 25'd65536;
      head_r      <= '0;
      ready_r     <= '0;
      total_r     <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) buf_size_r <= cfg_wr_data;
      head_r  <= head_nxt;
      ready_r <= ready_nxt;
      total_r <= total_nxt;
      used_r  <= used_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_data_r};

endmodule

>>> src/tcpr_checker.sv
// Port-level checker for the TCP reassembly interval tracker and its bind.
// Depends on the top level's port list and RANGE_SLOTS parameter only.
module tcpr_port_checks #(
  parameter int RANGE_SLOTS = 8
) (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped while stalled");

  // One command in flight: input closes right after a transfer.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second command taken while busy");

  // No result too soon after a transfer, checked while no result is pending.
  a_min_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> ##1 !$rose(out_tvalid))
    else $error("result too early");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[2:0] <= 3'd4)
    else $error("status code out of range");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && RANGE_SLOTS < 16 |-> 32'(out_tdata[120:117]) <= RANGE_SLOTS)
    else $error("range count above table size");

endmodule

bind tcp_reassembly_interval_tracker tcpr_port_checks #(.RANGE_SLOTS(RANGE_SLOTS))
  u_tcpr_port_checks (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
